/* rtl/u2c_pkg.sv */
// shared types and constants for the utf-8 to cyrillic codepage transcoder
package u2c_pkg;

  localparam logic [7:0]  SUBST_RESET  = 8'h3F;

  localparam logic [10:0] CP_UPPER_LO  = 11'h410;
  localparam logic [10:0] CP_UPPER_HI  = 11'h42F;
  localparam logic [10:0] CP_LOWER_LO  = 11'h430;
  localparam logic [10:0] CP_LOWER_HI  = 11'h43F;
  localparam logic [10:0] CP_LOWER2_LO = 11'h440;
  localparam logic [10:0] CP_LOWER2_HI = 11'h44F;
  localparam logic [10:0] CP_IO_UPPER  = 11'h401;
  localparam logic [10:0] CP_IO_LOWER  = 11'h451;

  localparam logic [7:0]  CODE_UPPER   = 8'h80;
  localparam logic [7:0]  CODE_LOWER   = 8'hA0;
  localparam logic [7:0]  CODE_LOWER2  = 8'hE0;
  localparam logic [7:0]  CODE_IO_UP   = 8'hF0;
  localparam logic [7:0]  CODE_IO_LOW  = 8'hF1;

  localparam logic [1:0]  SKIP_THREE   = 2'd2;
  localparam logic [1:0]  SKIP_FOUR    = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_code;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic       pending_lead;
    logic [4:0] lead_bits;
    logic [1:0] skip_count;
  } u2c_state_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } u2c_lookup_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
    u2c_state_t nxt;
  } u2c_fresh_t;

  typedef struct packed {
    logic [1:0] num;
    out_item_t  res0;
    out_item_t  res1;
    u2c_state_t nxt;
  } u2c_dec_t;

endpackage

/* rtl/u2c_decode.sv */
// per-byte decode: state update and up to two result codes
module u2c_decode import u2c_pkg::*; (
  input  in_item_t   item_i,
  input  u2c_state_t state_i,
  input  logic [7:0] subst_i,
  output u2c_dec_t   dec_o
);

  function automatic u2c_lookup_t cyr_lookup(input logic [10:0] cp);
    u2c_lookup_t r;
    r.hit  = 1'b1;
    r.code = '0;
    if (cp >= CP_UPPER_LO && cp <= CP_UPPER_HI) begin
      r.code = CODE_UPPER + 8'(cp - CP_UPPER_LO);
    end else if (cp >= CP_LOWER_LO && cp <= CP_LOWER_HI) begin
      r.code = CODE_LOWER + {4'h0, cp[3:0]};
    end else if (cp >= CP_LOWER2_LO && cp <= CP_LOWER2_HI) begin
      r.code = CODE_LOWER2 + {4'h0, cp[3:0]};
    end else if (cp == CP_IO_UPPER) begin
      r.code = CODE_IO_UP;
    end else if (cp == CP_IO_LOWER) begin
      r.code = CODE_IO_LOW;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  // byte handled with no lead waiting
  function automatic u2c_fresh_t fresh(input logic [7:0] b, input logic eot,
                                       input logic [7:0] subst);
    u2c_fresh_t f;
    f.hit  = 1'b1;
    f.code = subst;
    f.nxt  = '0;
    if (!b[7]) begin
      f.code = b;
    end else if (b[7:5] == 3'b110) begin
      if (!eot) begin
        f.hit              = 1'b0;
        f.nxt.pending_lead = 1'b1;
        f.nxt.lead_bits    = b[4:0];
      end
    end else if (b[7:4] == 4'b1110) begin
      f.nxt.skip_count = eot ? 2'd0 : SKIP_THREE;
    end else if (b[7:3] == 5'b11110) begin
      f.nxt.skip_count = eot ? 2'd0 : SKIP_FOUR;
    end
    return f;
  endfunction

  u2c_lookup_t lk;
  u2c_fresh_t  fr;

  assign lk = cyr_lookup({state_i.lead_bits, item_i.in_byte[5:0]});
  assign fr = fresh(item_i.in_byte, item_i.end_of_text, subst_i);

  always_comb begin
    dec_o     = '0;
    dec_o.nxt = state_i;
    if (state_i.skip_count != 2'd0) begin
      dec_o.nxt.skip_count = item_i.end_of_text ? 2'd0 : state_i.skip_count - 2'd1;
    end else if (state_i.pending_lead) begin
      if (lk.hit) begin
        dec_o.num  = 2'd1;
        dec_o.res0 = '{out_code: lk.code, run_last: 1'b1};
        dec_o.nxt  = '0;
      end else begin
        // miss: substitute, then the second byte taken afresh
        dec_o.res0.out_code = subst_i;
        dec_o.nxt           = fr.nxt;
        if (fr.hit) begin
          dec_o.num           = 2'd2;
          dec_o.res0.run_last = 1'b0;
          dec_o.res1          = '{out_code: fr.code, run_last: 1'b1};
        end else begin
          dec_o.num           = 2'd1;
          dec_o.res0.run_last = 1'b1;
        end
      end
    end else begin
      dec_o.nxt = fr.nxt;
      if (fr.hit) begin
        dec_o.num  = 2'd1;
        dec_o.res0 = '{out_code: fr.code, run_last: 1'b1};
      end
    end
  end

endmodule

/* rtl/u2c_res_fifo.sv */
// two-entry result queue, takes up to two results per cycle
module u2c_res_fifo import u2c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_num_i,
  input  out_item_t  push0_i,
  input  out_item_t  push1_i,
  output logic [1:0] free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_o
);

  out_item_t  mem_q [2];
  logic [1:0] count_q, count_d;
  logic       rd_ptr_q, wr_ptr_q;
  logic       pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != 2'd0);
  assign out_o       = mem_q[rd_ptr_q];
  assign free_o      = 2'd2 - count_q;
  assign count_d     = count_q + push_num_i - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_q ^ pop;
      wr_ptr_q <= wr_ptr_q ^ push_num_i[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[~wr_ptr_q] <= push1_i;
    end
  end

endmodule

/* rtl/utf8_to_cyrillic_codepage_core.sv */
// top level of the utf-8 to cyrillic codepage transcoder
//
// input channel: one utf-8 byte per transfer (in_valid_i / in_stall_o), with a
// flag marking the last byte of a string. output channel: one display code per
// transfer (out_valid_o / out_stall_i), run_last marks the last code caused by
// an input byte. a byte gives zero, one or two codes.
// the user writes the substitute code through cfg_we_i / cfg_wdata_i only
// while idle; the block itself does not enforce this. timing: one byte is
// accepted per cycle while each byte gives at most one code and the receiver
// does not stall. a byte is registered, decoded in the following cycle and its
// codes pushed into a two-entry result queue. a byte giving two codes waits
// until the queue is empty, holding the input while a code is still queued;
// its two codes then sit in the queue together, so the second is ready as soon
// as the first leaves. when the receiver stalls, the queue fills and the input
// register holds, raising in_stall_o; nothing is lost. reset empties both
// stages, clears the lead and skip state and sets the substitute code to '?'.
module utf8_to_cyrillic_codepage_core import u2c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic       in_valid_q, in_valid_d;
  in_item_t   in_q;
  u2c_state_t state_q, state_d;
  logic [7:0] subst_q;
  u2c_dec_t   dec;
  logic [1:0] free;
  logic       advance, accept;
  logic [1:0] push_num;

  u2c_decode u_decode (
    .item_i  (in_q),
    .state_i (state_q),
    .subst_i (subst_q),
    .dec_o   (dec)
  );

  assign advance    = in_valid_q && (dec.num <= free);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_num   = advance ? dec.num : 2'd0;
  assign in_valid_d = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign state_d    = advance ? dec.nxt : state_q;

  u2c_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (push_num),
    .push0_i     (dec.res0),
    .push1_i     (dec.res1),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
      subst_q    <= SUBST_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
      if (cfg_we_i) begin
        subst_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
  end

endmodule

/* rtl/u2c_checker.sv */
// port-level checks for the transcoder top level
module u2c_checker import u2c_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input out_item_t  out_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_o))
    else $error("output payload changed while stalled");

  // the second code of a byte is queued together with the first
  a_second_code_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_o.run_last |=> out_valid_o)
    else $error("second code of a byte not ready after the first");

  // input stall only rises after an input transfer
  a_stall_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall raised with no transfer in flight");

endmodule

bind utf8_to_cyrillic_codepage_core u2c_checker u_checker (.*);

/* tb/tb_utf8_to_cyrillic_codepage_core.sv */
// testbench for the utf-8 to cyrillic codepage transcoder: directed and random byte streams
`timescale 1ns / 1ps

module tb_utf8_to_cyrillic_codepage_core;
  import u2c_pkg::*;

  localparam logic [10:0] UPPER_FIRST  = 11'h410;
  localparam logic [10:0] UPPER_LAST   = 11'h42F;
  localparam logic [10:0] LOWER_FIRST  = 11'h430;
  localparam logic [10:0] LOWER_LAST   = 11'h43F;
  localparam logic [10:0] LOWER2_FIRST = 11'h440;
  localparam logic [10:0] LOWER2_LAST  = 11'h44F;
  localparam logic [10:0] IO_UPPER_CP  = 11'h401;
  localparam logic [10:0] IO_LOWER_CP  = 11'h451;
  localparam logic [7:0]  UPPER_BASE   = 8'h80;
  localparam logic [7:0]  LOWER_BASE   = 8'hA0;
  localparam logic [7:0]  LOWER2_BASE  = 8'hE0;
  localparam logic [7:0]  IO_UPPER_CODE = 8'hF0;
  localparam logic [7:0]  IO_LOWER_CODE = 8'hF1;
  localparam logic [7:0]  SUBST_DEFAULT = 8'h3F;
  localparam int          HOLD_CYCLES  = 90;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_item_t   in_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_o;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;

  utf8_to_cyrillic_codepage_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // decoder copy kept in step with accepted bytes
  logic [7:0] subst_code = SUBST_DEFAULT;
  logic       lead_wait = 1'b0;
  logic [4:0] lead_low = 5'd0;
  logic [1:0] skip_left = 2'd0;

  in_item_t   text_bytes[$];
  out_item_t  pending_codes[$];
  int         bytes_sent = 0;
  int         bytes_taken = 0;
  int         fails = 0;
  bit         in_took = 1'b0;
  bit         calm = 1'b0;
  bit         held = 1'b0;
  int         send_gap = 0;
  int         recv_gap = 0;
  int         hold_left = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit cyr_map(input logic [10:0] cp, output logic [7:0] code);
    code = 8'h00;
    if (cp >= UPPER_FIRST && cp <= UPPER_LAST) begin
      code = UPPER_BASE + 8'(cp - UPPER_FIRST);
      return 1'b1;
    end
    if (cp >= LOWER_FIRST && cp <= LOWER_LAST) begin
      code = LOWER_BASE + 8'(cp - LOWER_FIRST);
      return 1'b1;
    end
    if (cp >= LOWER2_FIRST && cp <= LOWER2_LAST) begin
      code = LOWER2_BASE + 8'(cp - LOWER2_FIRST);
      return 1'b1;
    end
    if (cp == IO_UPPER_CP) begin
      code = IO_UPPER_CODE;
      return 1'b1;
    end
    if (cp == IO_LOWER_CP) begin
      code = IO_LOWER_CODE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // byte seen with no lead waiting
  task automatic decode_fresh(input logic [7:0] b, input logic eot, output bit got,
                              output logic [7:0] code);
    got = 1'b1;
    code = subst_code;
    if (b < 8'h80) begin
      code = b;
    end else if (b[7:5] == 3'b110) begin
      if (!eot) begin
        got = 1'b0;
        lead_wait = 1'b1;
        lead_low = b[4:0];
      end
    end else if (b[7:4] == 4'b1110) begin
      skip_left = eot ? 2'd0 : 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      skip_left = eot ? 2'd0 : 2'd3;
    end
  endtask

  task automatic predict_codes(input in_item_t it);
    logic [7:0] codes[2];
    logic [7:0] code;
    logic [10:0] cp;
    out_item_t  res;
    bit         got;
    int         n;
    n = 0;
    if (skip_left != 2'd0) begin
      skip_left = it.end_of_text ? 2'd0 : skip_left - 2'd1;
      return;
    end
    if (lead_wait) begin
      cp = {lead_low, it.in_byte[5:0]};
      lead_wait = 1'b0;
      lead_low = 5'd0;
      if (cyr_map(cp, code)) begin
        codes[n] = code;
        n++;
      end else begin
        codes[n] = subst_code;
        n++;
        decode_fresh(it.in_byte, it.end_of_text, got, code);
        if (got) begin
          codes[n] = code;
          n++;
        end
      end
    end else begin
      decode_fresh(it.in_byte, it.end_of_text, got, code);
      if (got) begin
        codes[n] = code;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      res.out_code = codes[k];
      res.run_last = (k == n - 1);
      pending_codes.push_back(res);
    end
  endtask

  // sample both channels and the register port
  always @(posedge clk_i) begin : monitor_p
    out_item_t want;
    in_took = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        subst_code = cfg_wdata_i;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_codes.size() == 0) begin
          $error("out_code: expected none, actual %02h", out_o.out_code);
          fails++;
        end else begin
          want = pending_codes.pop_front();
          if (out_o.out_code !== want.out_code) begin
            $error("out_code: expected %02h, actual %02h", want.out_code, out_o.out_code);
            fails++;
          end
          if (out_o.run_last !== want.run_last) begin
            $error("run_last: expected %0b, actual %0b", want.run_last, out_o.run_last);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_took = 1'b1;
        bytes_taken++;
        predict_codes(in_i);
      end
    end
  end

  // byte sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(0, 6);
        in_valid_i <= 1'b0;
      end else if (text_bytes.size() != 0) begin
        in_i <= text_bytes.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // code receiver, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (!held && bytes_taken >= 400) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      recv_gap = $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    in_item_t it;
    it.in_byte = b;
    it.end_of_text = eot;
    text_bytes.push_back(it);
    bytes_sent++;
  endtask

  task automatic add_text();
    logic [7:0]  txt[$];
    logic [10:0] cp;
    int          nchars;
    int          r;
    bit          flag;
    nchars = $urandom_range(1, 10);
    for (int k = 0; k < nchars; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          r = $urandom_range(0, 65);
          cp = (r < 64) ? UPPER_FIRST + 11'(r) : (r == 64 ? IO_UPPER_CP : IO_LOWER_CP);
          txt.push_back({3'b110, cp[10:6]});
          txt.push_back({2'b10, cp[5:0]});
        end
        3, 4: txt.push_back(8'($urandom_range(0, 127)));
        5: begin
          cp = 11'($urandom_range(11'h080, 11'h7FF));
          txt.push_back({3'b110, cp[10:6]});
          txt.push_back({2'b10, cp[5:0]});
        end
        6: begin
          txt.push_back({4'b1110, 4'($urandom)});
          repeat (2) txt.push_back({2'b10, 6'($urandom)});
        end
        7: begin
          txt.push_back({5'b11110, 3'($urandom)});
          repeat (3) txt.push_back({2'b10, 6'($urandom)});
        end
        8: txt.push_back(8'($urandom_range(0, 255)));
        default: begin
          // lead with a random, possibly broken second byte
          txt.push_back({3'b110, 5'($urandom)});
          txt.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      r = $urandom_range(1, txt.size());
      while (txt.size() > r) void'(txt.pop_back());
    end
    flag = ($urandom_range(0, 3) != 0);
    foreach (txt[k]) send_byte(txt[k], flag && (k == txt.size() - 1));
  endtask

  task automatic add_random(input int nbytes);
    int target;
    target = bytes_sent + nbytes;
    while (bytes_sent < target) add_text();
  endtask

  task automatic wait_drained();
    while (bytes_taken != bytes_sent || pending_codes.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_subst(input logic [7:0] value);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hD0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'hD1, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hD0, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'hD1, 1'b0);
    send_byte(8'h91, 1'b1);
    // miss, second byte handled again as a stray byte
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hC2, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hD0, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // text ends inside a skip
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hF0, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF8, 1'b1);

    write_subst(8'h00);
    add_random(300);
    write_subst(8'hFF);
    add_random(300);
    write_subst(8'($urandom_range(0, 255)));
    add_random(250);
    while (text_bytes.size() != 0) @(posedge clk_i);
    calm = 1'b1;
    add_random(250);

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (fails == 0 && pending_codes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/u2c_pkg.sv
rtl/u2c_decode.sv
rtl/u2c_res_fifo.sv
rtl/utf8_to_cyrillic_codepage_core.sv
rtl/u2c_checker.sv
tb/tb_utf8_to_cyrillic_codepage_core.sv
